### hdl/cpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpd_pkg;

    typedef enum logic [2:0] {
        PH_ID_LO   = 3'd0,
        PH_ID_HI   = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SUM_LO  = 3'd5,
        PH_SUM_HI  = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        K_DATA  = 3'd0,
        K_GOOD  = 3'd1,
        K_IDERR = 3'd2,
        K_CKERR = 3'd3,
        K_ABORT = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [15:0] length;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

### hdl/cpd_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module cpd_parse (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_op,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [15:0]     i_expected_id,
    output cpd_pkg::t_result     o_res,
    output logic                 o_res_valid
);
    import cpd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_latched_id, n_latched_id;
    logic [7:0]  r_header_low, n_header_low;
    logic [15:0] r_payload_length, n_payload_length;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [15:0] r_running_sum, n_running_sum;
    logic [7:0]  r_sum_low, n_sum_low;
    logic [15:0] w_sum_add;
    logic [15:0] w_length;
    logic [15:0] w_left_dec;
    logic        w_ok;

    assign w_sum_add  = r_running_sum + {8'd0, i_rx_byte};
    assign w_length   = {i_rx_byte, r_header_low};
    assign w_left_dec = r_bytes_left - 16'd1;
    assign w_ok       = (r_running_sum[7:0] == r_sum_low) &&
                        (r_running_sum[15:8] == i_rx_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_ID_LO;
            r_latched_id     <= '0;
            r_header_low     <= '0;
            r_payload_length <= '0;
            r_bytes_left     <= '0;
            r_running_sum    <= '0;
            r_sum_low        <= '0;
        end else begin
            r_phase          <= n_phase;
            r_latched_id     <= n_latched_id;
            r_header_low     <= n_header_low;
            r_payload_length <= n_payload_length;
            r_bytes_left     <= n_bytes_left;
            r_running_sum    <= n_running_sum;
            r_sum_low        <= n_sum_low;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_latched_id     = r_latched_id;
        n_header_low     = r_header_low;
        n_payload_length = r_payload_length;
        n_bytes_left     = r_bytes_left;
        n_running_sum    = r_running_sum;
        n_sum_low        = r_sum_low;
        o_res_valid      = 1'b0;
        o_res.kind       = K_DATA;
        o_res.data       = 8'd0;
        o_res.last       = 1'b0;

        if (i_accept) begin
            if (i_op) begin
                // abort while idle drops silently
                o_res_valid = (r_phase != PH_ID_LO) && (r_phase <= PH_SUM_HI);
                o_res.kind  = K_ABORT;
                o_res.last  = 1'b1;
                n_phase     = PH_ID_LO;
            end else begin
                case (r_phase)
                    PH_ID_HI: begin
                        n_latched_id  = r_latched_id ^ {i_rx_byte, 8'd0};
                        n_running_sum = w_sum_add;
                        n_phase       = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_header_low  = i_rx_byte;
                        n_running_sum = w_sum_add;
                        n_phase       = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_payload_length = w_length;
                        n_running_sum    = w_sum_add;
                        if (r_latched_id != 16'd0) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = K_IDERR;
                            o_res.last  = 1'b1;
                            n_phase     = PH_ID_LO;
                        end else begin
                            n_bytes_left = w_length;
                            n_phase = (w_length == 16'd0) ? PH_SUM_LO : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_running_sum = w_sum_add;
                        n_bytes_left  = w_left_dec;
                        if (w_left_dec == 16'd0) begin
                            n_phase = PH_SUM_LO;
                        end
                        o_res_valid = 1'b1;
                        o_res.data  = i_rx_byte;
                    end
                    PH_SUM_LO: begin
                        n_sum_low = i_rx_byte;
                        n_phase   = PH_SUM_HI;
                    end
                    PH_SUM_HI: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = w_ok ? K_GOOD : K_CKERR;
                        o_res.last  = 1'b1;
                        n_phase     = PH_ID_LO;
                    end
                    default: begin
                        // first header byte; also recovers from an unused phase code
                        n_latched_id     = i_expected_id ^ {8'd0, i_rx_byte};
                        n_payload_length = 16'd0;
                        n_bytes_left     = 16'd0;
                        n_running_sum    = {8'd0, i_rx_byte};
                        n_phase          = PH_ID_HI;
                    end
                endcase
            end
        end
        o_res.length = n_payload_length;
    end

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_left != 16'd0)
        else $error("payload phase with no bytes left");

    a_abort_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_op |=> r_phase == PH_ID_LO)
        else $error("abort did not return to header");

    a_status_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_op && r_phase == PH_SUM_HI |=> r_phase == PH_ID_LO)
        else $error("frame end did not return to header");

    a_data_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == K_DATA |-> !o_res.last && r_phase == PH_PAYLOAD)
        else $error("payload beat outside payload phase");

endmodule

`default_nettype wire

### hdl/cpd_outreg.sv
`timescale 1ns / 1ps
`default_nettype none

module cpd_outreg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cpd_pkg::t_result i_res,
    input  wire logic            i_res_valid,
    input  wire logic            i_stall,
    output logic                 o_valid,
    output cpd_pkg::t_result     o_res,
    output logic                 o_full
);
    import cpd_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_take;

    assign w_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                // drain the skid beat first; upstream is stalled meanwhile
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_res;
                n_out_valid = i_res_valid;
            end
        end else if (i_res_valid) begin
            // hold the new beat while the output waits
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat with empty output register");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && r_out_valid && i_stall && !r_skid_valid |=> r_skid_valid)
        else $error("beat lost while output stalled");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_stall |=> r_out_valid && !r_skid_valid)
        else $error("skid beat not moved forward");

endmodule

`default_nettype wire

### hdl/camera_packet_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Camera packet deframer. Each input beat is one received byte (op 0) or an
// abort (op 1). A frame is a 16-bit little-endian ID, a 16-bit little-endian
// payload length, the payload and a 16-bit sum over ID, length and payload,
// low byte first. Payload bytes come out as kind 0 while they arrive; the frame
// closes with one status beat (good, ID mismatch after the header, checksum
// error, or aborted) with last set and the header length. On an error status
// the consumer drops the payload it has taken. An abort between frames gives
// nothing. One byte is taken per clock while o_stall is low: the header,
// counter and sum update sit between the input and a result register, with
// a one-beat skid register behind it, so o_stall rises only when both hold a
// waiting result. The result of each accepted byte is registered.
module camera_packet_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [15:0] i_expected_id,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_data,
    output logic [15:0]      o_length,
    output logic             o_last
);
    import cpd_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    logic    w_full;
    t_result w_res;
    t_result w_out;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    cpd_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_op          (i_op),
        .i_rx_byte     (i_rx_byte),
        .i_expected_id (i_expected_id),
        .o_res         (w_res),
        .o_res_valid   (w_res_valid)
    );

    cpd_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (w_res),
        .i_res_valid (w_res_valid),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (w_out),
        .o_full      (w_full)
    );

    assign o_kind   = w_out.kind;
    assign o_data   = w_out.data;
    assign o_length = w_out.length;
    assign o_last   = w_out.last;

endmodule

`default_nettype wire
